// ----- design/bpa_pkg.sv -----
// Shared types and constants of the buddy page allocator.
// Used by bpa_ctrl, bpa_dp and buddy_page_allocator_top; depends on nothing.
package bpa_pkg;

  // Default sizes of the allocator.
  localparam int ORDER_LIMIT_DEF = 20;
  localparam int LIST_DEPTH_DEF  = 1024;
  localparam int PAGE_BITS_DEF   = 24;

  // Fixed field widths.
  localparam int PW = 24;  // page numbers on the ports
  localparam int KW = 5;   // block order counter

  // Fixed scheme constants.
  localparam int RES_ORDER  = 9;    // order of a 2 MB block
  localparam int CHUNK_SIZE = 512;  // pages in a 2 MB block

  // Operation codes.
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_FREE    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_REQ  = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_MEMORY_MB = 2'd0;
  localparam logic [1:0] REG_KERNEL_MB = 2'd1;
  localparam logic [1:0] REG_MAX_ORDER = 2'd2;

  // Configuration registers.
  typedef struct packed {
    logic [15:0] memory_mb;
    logic [15:0] kernel_mb;
    logic [4:0]  max_order;
  } cfg_t;

  // Datapath commands, one per controller step.
  typedef enum logic [4:0] {
    C_NOP,
    C_LOAD,
    C_INIT_CLR,
    C_INIT_SETK,
    C_INIT_STEP,
    C_LOG_STEP,
    C_ALLOC_SET,
    C_SRCH_BACK,
    C_SRCH_FRONT,
    C_CAP,
    C_SPLIT,
    C_RES_START,
    C_RES_OUT9,
    C_CHUNK,
    C_RES_OUTL,
    C_FREE_PUSH,
    C_SET_BAD
  } dp_cmd_e;

  // Datapath status toward the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       p_gt_m;
    logic       p_ge_m;
    logic       init_fit;
    logic       bad_range;
    logic       log_more;
    logic       k_gt_em;
    logic       srch_empty;
    logic       split_more;
    logic       res9;
    logic       chunk_more;
    logic       pushed_zero;
  } dp_stat_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_INIT_CLR,
    S_INIT_CHK,
    S_INIT_STEP,
    S_FREE_CHK,
    S_LOG,
    S_ALLOC_SET,
    S_SRCH_A,
    S_CAP_A,
    S_SPLIT,
    S_RES_START,
    S_RES_OUT9,
    S_SRCH_R,
    S_CAP_R,
    S_CHUNK,
    S_RES_OUTL,
    S_FREE_PUSH,
    S_DONE
  } ctrl_state_e;

endpackage

// ----- design/bpa_ctrl.sv -----
// Sequencer of the buddy page allocator: steps each operation through the datapath.
// Depends on bpa_pkg.
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  bpa_pkg::dp_stat_t stat_i,
  output logic              in_stall_o,
  output bpa_pkg::dp_cmd_e  cmd_o,
  output logic              out_load_o
);

  bpa_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bpa_pkg::S_DISP;
      end
      bpa_pkg::S_DISP: begin
        case (stat_i.op)
          bpa_pkg::OP_INIT:    state_d = bpa_pkg::S_INIT_CLR;
          bpa_pkg::OP_ALLOC:   state_d = bpa_pkg::S_LOG;
          bpa_pkg::OP_RESERVE: state_d = bpa_pkg::S_RES_START;
          default:             state_d = bpa_pkg::S_FREE_CHK;
        endcase
      end
      bpa_pkg::S_INIT_CLR: begin
        state_d = stat_i.p_gt_m ? bpa_pkg::S_DONE : bpa_pkg::S_INIT_CHK;
      end
      bpa_pkg::S_INIT_CHK: begin
        state_d = stat_i.p_ge_m ? bpa_pkg::S_DONE : bpa_pkg::S_INIT_STEP;
      end
      bpa_pkg::S_INIT_STEP: begin
        if (stat_i.init_fit) state_d = bpa_pkg::S_INIT_CHK;
      end
      bpa_pkg::S_FREE_CHK: begin
        state_d = stat_i.bad_range ? bpa_pkg::S_DONE : bpa_pkg::S_LOG;
      end
      bpa_pkg::S_LOG: begin
        if (!stat_i.log_more) begin
          state_d = (stat_i.op == bpa_pkg::OP_ALLOC) ? bpa_pkg::S_ALLOC_SET
                                                     : bpa_pkg::S_FREE_PUSH;
        end
      end
      bpa_pkg::S_ALLOC_SET: begin
        state_d = stat_i.k_gt_em ? bpa_pkg::S_DONE : bpa_pkg::S_SRCH_A;
      end
      bpa_pkg::S_SRCH_A: begin
        if (stat_i.k_gt_em) state_d = bpa_pkg::S_DONE;
        else if (!stat_i.srch_empty) state_d = bpa_pkg::S_CAP_A;
      end
      bpa_pkg::S_CAP_A:   state_d = bpa_pkg::S_SPLIT;
      bpa_pkg::S_SPLIT: begin
        if (!stat_i.split_more) state_d = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_RES_START: begin
        state_d = stat_i.res9 ? bpa_pkg::S_RES_OUT9 : bpa_pkg::S_SRCH_R;
      end
      bpa_pkg::S_RES_OUT9: state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_SRCH_R: begin
        if (stat_i.k_gt_em) state_d = bpa_pkg::S_DONE;
        else if (!stat_i.srch_empty) state_d = bpa_pkg::S_CAP_R;
      end
      bpa_pkg::S_CAP_R:   state_d = bpa_pkg::S_CHUNK;
      bpa_pkg::S_CHUNK: begin
        if (!stat_i.chunk_more) begin
          state_d = stat_i.pushed_zero ? bpa_pkg::S_DONE : bpa_pkg::S_RES_OUTL;
        end
      end
      bpa_pkg::S_RES_OUTL:  state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_FREE_PUSH: state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_DONE: begin
        if (out_free_i) state_d = bpa_pkg::S_IDLE;
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // Outputs: the datapath command of each step.
  always_comb begin
    cmd_o      = bpa_pkg::C_NOP;
    out_load_o = 1'b0;
    in_stall_o = (state_q != bpa_pkg::S_IDLE);
    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (in_valid_i) cmd_o = bpa_pkg::C_LOAD;
      end
      bpa_pkg::S_INIT_CLR:  cmd_o = bpa_pkg::C_INIT_CLR;
      bpa_pkg::S_INIT_CHK: begin
        if (!stat_i.p_ge_m) cmd_o = bpa_pkg::C_INIT_SETK;
      end
      bpa_pkg::S_INIT_STEP: cmd_o = bpa_pkg::C_INIT_STEP;
      bpa_pkg::S_FREE_CHK: begin
        if (stat_i.bad_range) cmd_o = bpa_pkg::C_SET_BAD;
      end
      bpa_pkg::S_LOG:       cmd_o = bpa_pkg::C_LOG_STEP;
      bpa_pkg::S_ALLOC_SET: cmd_o = bpa_pkg::C_ALLOC_SET;
      bpa_pkg::S_SRCH_A:    cmd_o = bpa_pkg::C_SRCH_BACK;
      bpa_pkg::S_CAP_A:     cmd_o = bpa_pkg::C_CAP;
      bpa_pkg::S_SPLIT:     cmd_o = bpa_pkg::C_SPLIT;
      bpa_pkg::S_RES_START: cmd_o = bpa_pkg::C_RES_START;
      bpa_pkg::S_RES_OUT9:  cmd_o = bpa_pkg::C_RES_OUT9;
      bpa_pkg::S_SRCH_R:    cmd_o = bpa_pkg::C_SRCH_FRONT;
      bpa_pkg::S_CAP_R:     cmd_o = bpa_pkg::C_CAP;
      bpa_pkg::S_CHUNK:     cmd_o = bpa_pkg::C_CHUNK;
      bpa_pkg::S_RES_OUTL:  cmd_o = bpa_pkg::C_RES_OUTL;
      bpa_pkg::S_FREE_PUSH: cmd_o = bpa_pkg::C_FREE_PUSH;
      bpa_pkg::S_DONE:      out_load_o = out_free_i;
      default: cmd_o = bpa_pkg::C_NOP;
    endcase
  end

endmodule

// ----- design/bpa_dp.sv -----
// Datapath of the buddy page allocator: deque store, deque pointers, counters.
// Depends on bpa_pkg; driven by bpa_ctrl commands.
module bpa_dp #(
  parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF,
  parameter int LIST_DEPTH  = bpa_pkg::LIST_DEPTH_DEF,
  parameter int PAGE_BITS   = bpa_pkg::PAGE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpa_pkg::dp_cmd_e       cmd_i,
  input  bpa_pkg::cfg_t          cfg_i,
  input  logic [1:0]             operation_i,
  input  logic [32:0]            size_bytes_i,
  input  logic [bpa_pkg::PW-1:0] start_page_i,
  input  logic [bpa_pkg::PW-1:0] end_page_i,
  output bpa_pkg::dp_stat_t      stat_o,
  output logic [bpa_pkg::PW-1:0] block_start_o,
  output logic [bpa_pkg::PW-1:0] block_end_o,
  output logic [1:0]             status_o,
  output logic [bpa_pkg::PW-1:0] free_pages_o
);

  localparam int NORD      = ORDER_LIMIT + 1;
  localparam int OW        = $clog2(NORD);
  localparam int HW        = $clog2(LIST_DEPTH);
  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int SUMW      = CW + 1;
  localparam int SW        = (PAGE_BITS < bpa_pkg::PW) ? PAGE_BITS : bpa_pkg::PW;
  localparam int MEM_DEPTH = NORD * LIST_DEPTH;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int FW        = PAGE_BITS;
  localparam int AW        = ((PAGE_BITS > 26) ? PAGE_BITS : 26) + 1;
  localparam int PW        = bpa_pkg::PW;
  localparam int KW        = bpa_pkg::KW;

  // Deque pointers and free count.
  logic [HW-1:0] head_q [NORD];
  logic [CW-1:0] cnt_q  [NORD];
  logic [FW-1:0] free_q;

  // Work registers.
  logic [1:0]    op_q, st_q;
  logic [24:0]   n_q, size_q;
  logic [PW-1:0] fs_q, fe_q, p_q, m_q, s_q, e_q, c_q, bs_q, be_q;
  logic [KW-1:0] k_q, ind_q;
  logic [15:0]   chunks_q, j_q, pushed_q;

  // Deque store, start and end of each block in one word.
  logic [2*SW-1:0] mem_q [MEM_DEPTH];
  logic [2*SW-1:0] rd_q;

  logic [KW-1:0] em;
  logic [PW-1:0] rd_s, rd_e, mid;
  logic          k_in, init_fit, log_more, split_more, chunk_more;
  logic [CW-1:0] cnt_k, cnt_9;
  logic [PW-1:0] kmask;
  logic [25:0]   p_plus;

  logic          push_en, push_ok;
  logic [KW-1:0] push_ord;
  logic [PW-1:0] push_s, push_e;
  logic [OW-1:0] push_idx, pop_idx;
  logic [CW-1:0] push_cnt, pop_cnt;
  logic [SUMW-1:0] push_sum, pop_sum;
  logic [HW-1:0] push_slot, pop_slot;
  logic [MAW-1:0] waddr, raddr;

  logic          pop_en, pop_front;
  logic [KW-1:0] pop_ord;

  logic          acc_add, acc_sub;
  logic [AW-1:0] acc_amt, free_ext, free_room, free_nx;

  // Effective largest order and read data fields.
  assign em   = (cfg_i.max_order > KW'(ORDER_LIMIT)) ? KW'(ORDER_LIMIT) : cfg_i.max_order;
  assign rd_s = PW'(rd_q[2*SW-1:SW]);
  assign rd_e = PW'(rd_q[SW-1:0]);
  assign mid  = s_q + ((e_q - s_q) >> 1);

  // Per-step conditions.
  assign k_in       = (k_q < KW'(NORD));
  assign cnt_k      = k_in ? cnt_q[k_q[OW-1:0]] : '0;
  assign cnt_9      = cnt_q[bpa_pkg::RES_ORDER];
  assign kmask      = PW'((25'd1 << k_q) - 25'd1);
  assign p_plus     = {2'b00, p_q} + (26'd1 << k_q);
  assign init_fit   = (k_q == '0) || (((p_q & kmask) == '0) && (p_plus <= {2'b00, m_q}));
  assign log_more   = (27'd1 << k_q) < {2'b00, n_q};
  assign split_more = (k_q > ind_q);
  assign chunk_more = (j_q < chunks_q);

  // Status toward the controller.
  always_comb begin
    stat_o.op          = op_q;
    stat_o.p_gt_m      = (cfg_i.kernel_mb > cfg_i.memory_mb);
    stat_o.p_ge_m      = (p_q >= m_q);
    stat_o.init_fit    = init_fit;
    stat_o.bad_range   = (fe_q < fs_q);
    stat_o.log_more    = log_more;
    stat_o.k_gt_em     = (k_q > em);
    stat_o.srch_empty  = (cnt_k == '0);
    stat_o.split_more  = split_more;
    stat_o.res9        = (cnt_9 != '0);
    stat_o.chunk_more  = chunk_more;
    stat_o.pushed_zero = (pushed_q == '0);
  end

  // Push selection.
  always_comb begin
    push_en  = 1'b0;
    push_ord = k_q;
    push_s   = p_q;
    push_e   = p_plus[PW-1:0] - PW'(1);
    case (cmd_i)
      bpa_pkg::C_INIT_STEP: push_en = init_fit;
      bpa_pkg::C_SPLIT: begin
        push_en  = split_more;
        push_ord = k_q - KW'(1);
        push_s   = s_q;
        push_e   = mid;
      end
      bpa_pkg::C_CHUNK: begin
        push_en  = chunk_more;
        push_ord = KW'(bpa_pkg::RES_ORDER);
        push_s   = c_q;
        push_e   = c_q + PW'(bpa_pkg::CHUNK_SIZE - 1);
      end
      bpa_pkg::C_FREE_PUSH: begin
        push_en = (k_q <= em);
        push_s  = fs_q;
        push_e  = fe_q;
      end
      default: push_en = 1'b0;
    endcase
  end

  // Pop selection.
  always_comb begin
    pop_en    = 1'b0;
    pop_front = 1'b0;
    pop_ord   = k_q;
    case (cmd_i)
      bpa_pkg::C_SRCH_BACK:  pop_en = (k_q <= em) && (cnt_k != '0);
      bpa_pkg::C_SRCH_FRONT: begin
        pop_en    = (k_q <= em) && (cnt_k != '0);
        pop_front = 1'b1;
      end
      bpa_pkg::C_RES_START: begin
        pop_en  = (cnt_9 != '0);
        pop_ord = KW'(bpa_pkg::RES_ORDER);
      end
      bpa_pkg::C_CHUNK: begin
        pop_en  = !chunk_more && (pushed_q != '0);
        pop_ord = KW'(bpa_pkg::RES_ORDER);
      end
      default: pop_en = 1'b0;
    endcase
  end

  // Ring slots and store addresses.
  assign push_idx = push_ord[OW-1:0];
  assign pop_idx  = pop_ord[OW-1:0];
  assign push_cnt = cnt_q[push_idx];
  assign pop_cnt  = cnt_q[pop_idx];
  assign push_ok  = push_en && (push_cnt < CW'(LIST_DEPTH));
  assign push_sum = SUMW'(head_q[push_idx]) + SUMW'(push_cnt);
  assign pop_sum  = SUMW'(head_q[pop_idx]) + SUMW'(pop_cnt) - SUMW'(1);
  assign push_slot = (push_sum >= SUMW'(LIST_DEPTH)) ? HW'(push_sum - SUMW'(LIST_DEPTH))
                                                     : HW'(push_sum);
  assign pop_slot  = pop_front ? head_q[pop_idx]
                   : ((pop_sum >= SUMW'(LIST_DEPTH)) ? HW'(pop_sum - SUMW'(LIST_DEPTH))
                                                     : HW'(pop_sum));
  assign waddr = MAW'(push_idx) * MAW'(LIST_DEPTH) + MAW'(push_slot);
  assign raddr = MAW'(pop_idx) * MAW'(LIST_DEPTH) + MAW'(pop_slot);

  // Free page accounting: one saturating add or subtract per step.
  always_comb begin
    acc_add = 1'b0;
    acc_sub = 1'b0;
    acc_amt = AW'(1) << k_q;
    case (cmd_i)
      bpa_pkg::C_INIT_STEP: acc_add = push_ok;
      bpa_pkg::C_FREE_PUSH: acc_add = push_ok;
      bpa_pkg::C_SPLIT: begin
        if (split_more) begin
          acc_sub = !push_ok;
          acc_amt = AW'(mid - s_q) + AW'(1);
        end else begin
          acc_sub = 1'b1;
          acc_amt = AW'(1) << ind_q;
        end
      end
      bpa_pkg::C_RES_OUT9: begin
        acc_sub = 1'b1;
        acc_amt = AW'(rd_e - rd_s) + AW'(1);
      end
      bpa_pkg::C_CHUNK: begin
        acc_sub = !chunk_more && (pushed_q == '0);
        acc_amt = AW'(size_q);
      end
      bpa_pkg::C_RES_OUTL: begin
        acc_sub = 1'b1;
        acc_amt = AW'(size_q) + AW'(bpa_pkg::CHUNK_SIZE) - (AW'(pushed_q) << 9);
      end
      default: acc_add = 1'b0;
    endcase
  end

  assign free_ext  = AW'(free_q);
  assign free_room = AW'({FW{1'b1}}) - free_ext;
  always_comb begin
    free_nx = free_ext;
    if (acc_add) begin
      free_nx = (acc_amt > free_room) ? AW'({FW{1'b1}}) : free_ext + acc_amt;
    end else if (acc_sub) begin
      free_nx = (acc_amt >= free_ext) ? '0 : free_ext - acc_amt;
    end
  end

  // Deque pointers and free count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int o = 0; o < NORD; o++) begin
        head_q[o] <= '0;
        cnt_q[o]  <= '0;
      end
      free_q <= '0;
    end else if (cmd_i == bpa_pkg::C_INIT_CLR) begin
      for (int o = 0; o < NORD; o++) begin
        head_q[o] <= '0;
        cnt_q[o]  <= '0;
      end
      free_q <= '0;
    end else begin
      free_q <= FW'(free_nx);
      if (push_ok) cnt_q[push_idx] <= push_cnt + CW'(1);
      if (pop_en) begin
        cnt_q[pop_idx] <= pop_cnt - CW'(1);
        if (pop_front) begin
          head_q[pop_idx] <= (head_q[pop_idx] == HW'(LIST_DEPTH - 1)) ? '0
                                                                       : head_q[pop_idx] + HW'(1);
        end
      end
    end
  end

  // Deque store with registered read.
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[waddr] <= {push_s[SW-1:0], push_e[SW-1:0]};
    if (pop_en) rd_q <= mem_q[raddr];
  end

  // Work registers per command.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bpa_pkg::C_LOAD: begin
        op_q <= operation_i;
        fs_q <= start_page_i;
        fe_q <= end_page_i;
        n_q  <= (operation_i == bpa_pkg::OP_FREE)
                ? ({1'b0, end_page_i} - {1'b0, start_page_i} + 25'd1)
                : {4'b0000, size_bytes_i[32:12]};
        st_q <= bpa_pkg::ST_OK;
        bs_q <= '0;
        be_q <= '0;
        k_q  <= '0;
      end
      bpa_pkg::C_INIT_CLR: begin
        p_q <= {cfg_i.kernel_mb, 8'h00};
        m_q <= {cfg_i.memory_mb, 8'h00};
        if (cfg_i.kernel_mb > cfg_i.memory_mb) st_q <= bpa_pkg::ST_BAD_REQ;
      end
      bpa_pkg::C_INIT_SETK: k_q <= em;
      bpa_pkg::C_INIT_STEP: begin
        if (init_fit) begin
          p_q <= p_plus[PW-1:0];
          if (!push_ok) st_q <= bpa_pkg::ST_OVERFLOW;
        end else begin
          k_q <= k_q - KW'(1);
        end
      end
      bpa_pkg::C_LOG_STEP: begin
        if (log_more) k_q <= k_q + KW'(1);
      end
      bpa_pkg::C_ALLOC_SET: begin
        ind_q <= k_q;
        if (k_q > em) st_q <= bpa_pkg::ST_NO_FREE;
      end
      bpa_pkg::C_SRCH_BACK, bpa_pkg::C_SRCH_FRONT: begin
        if (k_q > em) st_q <= bpa_pkg::ST_NO_FREE;
        else if (cnt_k == '0) k_q <= k_q + KW'(1);
      end
      bpa_pkg::C_CAP: begin
        s_q      <= rd_s;
        e_q      <= rd_e;
        c_q      <= rd_s;
        size_q   <= {1'b0, rd_e} - {1'b0, rd_s} + 25'd1;
        chunks_q <= 16'(({1'b0, rd_e} - {1'b0, rd_s} + 25'd1) >> 9);
        j_q      <= '0;
        pushed_q <= '0;
      end
      bpa_pkg::C_SPLIT: begin
        if (split_more) begin
          k_q <= k_q - KW'(1);
          s_q <= mid + PW'(1);
          if (!push_ok) st_q <= bpa_pkg::ST_OVERFLOW;
        end else begin
          bs_q <= s_q;
        end
      end
      bpa_pkg::C_RES_START: begin
        if (cnt_9 == '0) k_q <= KW'(bpa_pkg::RES_ORDER + 1);
      end
      bpa_pkg::C_RES_OUT9, bpa_pkg::C_RES_OUTL: begin
        bs_q <= rd_s;
        be_q <= rd_e;
      end
      bpa_pkg::C_CHUNK: begin
        if (chunk_more) begin
          j_q <= j_q + 16'd1;
          c_q <= c_q + PW'(bpa_pkg::CHUNK_SIZE);
          if (push_ok) pushed_q <= pushed_q + 16'd1;
          else st_q <= bpa_pkg::ST_OVERFLOW;
        end else if (pushed_q == '0) begin
          st_q <= bpa_pkg::ST_NO_FREE;
        end
      end
      bpa_pkg::C_FREE_PUSH: begin
        if (k_q > em) st_q <= bpa_pkg::ST_BAD_REQ;
        else if (!push_ok) st_q <= bpa_pkg::ST_OVERFLOW;
      end
      bpa_pkg::C_SET_BAD: st_q <= bpa_pkg::ST_BAD_REQ;
      default: st_q <= st_q;
    endcase
  end

  // Result fields.
  assign block_start_o = bs_q;
  assign block_end_o   = be_q;
  assign status_o      = st_q;
  assign free_pages_o  = PW'(free_q);

`ifndef SYNTH
  // A pop never hits an empty deque.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |-> (pop_cnt != '0))
    else $error("pop from empty deque");

  // Store read data is captured only right after a pop issued the read.
  a_cap_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == bpa_pkg::C_CAP) |-> $past(pop_en))
    else $error("capture without a preceding pop");

  // A clearing step leaves the free count at zero.
  a_clear_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == bpa_pkg::C_INIT_CLR) |=> (free_q == '0))
    else $error("free count not cleared by init");
`endif

endmodule

// ----- design/buddy_page_allocator_top.sv -----
// Buddy page allocator: a page allocator with one free deque per block order.
// Channels: a request word in (valid/stall) and a result word out (valid/stall).
// Configuration through an APB-style port: memory_mb at 0x0, kernel_mb at 0x4,
// max_order at 0x8. Registers are to be written only while the block is idle;
// the block itself does not enforce this. Each accepted request yields exactly
// one result word. Requests run one at a time through the sequencer: allocate
// and free step once per order in the size rounding, allocate once per order
// searched and per split, reserve once per order searched and per 512-page
// chunk, init once per order tried for each block laid down. The deque store
// has one write and one read port. Results go to an output register, so the
// next request is taken while a result still waits; a stalled receiver holds
// the result and blocks completion of the following request only.
// Reset clears the deques, the free page count and the registers to their
// defaults; no clearing pass is run, the store content is left as is.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
module buddy_page_allocator_top #(
  parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF,
  parameter int LIST_DEPTH  = bpa_pkg::LIST_DEPTH_DEF,
  parameter int PAGE_BITS   = bpa_pkg::PAGE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             operation_i,
  input  logic [32:0]            size_bytes_i,
  input  logic [bpa_pkg::PW-1:0] start_page_i,
  input  logic [bpa_pkg::PW-1:0] end_page_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [bpa_pkg::PW-1:0] block_start_o,
  output logic [bpa_pkg::PW-1:0] block_end_o,
  output logic [1:0]             status_o,
  output logic [bpa_pkg::PW-1:0] free_pages_o
);

  bpa_pkg::cfg_t     cfg_q;
  bpa_pkg::dp_stat_t stat;
  bpa_pkg::dp_cmd_e  cmd;
  logic              out_load, out_free, cfg_wr;
  logic              out_valid_q;
  logic [bpa_pkg::PW-1:0] dp_bs, dp_be, dp_free;
  logic [1:0]        dp_st;
  logic [bpa_pkg::PW-1:0] bs_q, be_q, fp_q;
  logic [1:0]        st_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_mb <= 16'd16384;
      cfg_q.kernel_mb <= 16'd0;
      cfg_q.max_order <= 5'd18;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bpa_pkg::REG_MEMORY_MB: cfg_q.memory_mb <= pwdata[15:0];
        bpa_pkg::REG_KERNEL_MB: cfg_q.kernel_mb <= pwdata[15:0];
        bpa_pkg::REG_MAX_ORDER: cfg_q.max_order <= pwdata[4:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      bpa_pkg::REG_MEMORY_MB: prdata = {16'h0000, cfg_q.memory_mb};
      bpa_pkg::REG_KERNEL_MB: prdata = {16'h0000, cfg_q.kernel_mb};
      bpa_pkg::REG_MAX_ORDER: prdata = {27'h0, cfg_q.max_order};
      default:                prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .out_load_o (out_load)
  );

  bpa_dp #(
    .ORDER_LIMIT (ORDER_LIMIT),
    .LIST_DEPTH  (LIST_DEPTH),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .operation_i   (operation_i),
    .size_bytes_i  (size_bytes_i),
    .start_page_i  (start_page_i),
    .end_page_i    (end_page_i),
    .stat_o        (stat),
    .block_start_o (dp_bs),
    .block_end_o   (dp_be),
    .status_o      (dp_st),
    .free_pages_o  (dp_free)
  );

  // Output register: holds a result word until the receiver takes it.
  assign out_free = !out_valid_q || !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bs_q <= dp_bs;
      be_q <= dp_be;
      st_q <= dp_st;
      fp_q <= dp_free;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign block_start_o = bs_q;
  assign block_end_o   = be_q;
  assign status_o      = st_q;
  assign free_pages_o  = fp_q;

endmodule
